[rtl/core/hnt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hnt_pkg
// shared constants and types for the held note tracker
// ----------------------------------------------------------------------------
package hnt_pkg;

    localparam int KIND_W = 8;
    localparam int CHAN_W = 4;
    localparam int NOTE_W = 7;
    localparam int VEL_W  = 7;

    // default sizing
    localparam int CHANNELS_DEF = 16;
    localparam int MAX_HELD_DEF = 32;

    // status codes
    localparam logic [KIND_W-1:0] ST_ALL_OFF = 8'h80;
    localparam logic [KIND_W-1:0] ST_CTRL    = 8'hB0;

    // one outgoing midi word
    typedef struct packed {
        logic [KIND_W-1:0] status_byte;
        logic [NOTE_W-1:0] data_one;
        logic [VEL_W-1:0]  data_two;
        logic              last;
    } out_word_t;

endpackage

[rtl/core/hnt_note_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hnt_note_ram
// held note list storage, one write and one registered read port
// ----------------------------------------------------------------------------
module hnt_note_ram #(
    parameter int DEPTH  = hnt_pkg::CHANNELS_DEF * hnt_pkg::MAX_HELD_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      aclk,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic [hnt_pkg::NOTE_W-1:0] rd_data,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [hnt_pkg::NOTE_W-1:0] wr_data
);

    logic [hnt_pkg::NOTE_W-1:0] mem [DEPTH];
    logic [hnt_pkg::NOTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds when no read is issued
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/hnt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hnt_ctrl
// message sequencer: pass-through, duplicate scan, append and channel flush
// ----------------------------------------------------------------------------
module hnt_ctrl #(
    parameter int CHANNELS = hnt_pkg::CHANNELS_DEF,
    parameter int MAX_HELD = hnt_pkg::MAX_HELD_DEF,
    parameter int ADDR_W   = (CHANNELS * MAX_HELD > 1) ? $clog2(CHANNELS * MAX_HELD) : 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [hnt_pkg::KIND_W-1:0]  s_status_kind,
    input  logic [hnt_pkg::CHAN_W-1:0]  s_channel,
    input  logic [hnt_pkg::NOTE_W-1:0]  s_note,
    input  logic [hnt_pkg::VEL_W-1:0]   s_velocity,
    // output stage
    input  logic                        out_free,
    output logic                        out_load,
    output hnt_pkg::out_word_t          out_word,
    // note memory
    output logic                        rd_en,
    output logic [ADDR_W-1:0]           rd_addr,
    input  logic [hnt_pkg::NOTE_W-1:0]  rd_data,
    output logic                        wr_en,
    output logic [ADDR_W-1:0]           wr_addr,
    output logic [hnt_pkg::NOTE_W-1:0]  wr_data
);

    localparam int CNT_W = $clog2(MAX_HELD + 1);
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PASS  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]                 state_reg, state_next;
    logic [CNT_W-1:0]           rd_idx_reg, rd_idx_next;
    logic                       pipe_valid_reg, pipe_valid_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [ADDR_W-1:0]          base_reg, base_next;
    logic [CH_W-1:0]            ch_idx_reg, ch_idx_next;
    logic [hnt_pkg::CHAN_W-1:0] ch_reg, ch_next;
    logic [hnt_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [hnt_pkg::NOTE_W-1:0] note_reg, note_next;
    logic [hnt_pkg::VEL_W-1:0]  vel_reg, vel_next;
    logic                       track_reg, track_next;

    // per channel fill counts
    logic [CNT_W-1:0] cnt_tab_reg [CHANNELS];
    logic             cnt_wr;
    logic [CNT_W-1:0] cnt_wr_val;

    logic [CH_W-1:0] s_ch_idx;
    logic            s_tracked;
    logic            accept;
    logic            more;
    logic            consume;
    logic            match;

    assign s_ch_idx  = s_channel[CH_W-1:0];
    assign s_tracked = (32'(s_channel) < CHANNELS);
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign more      = (rd_idx_reg < cnt_reg);
    assign consume   = pipe_valid_reg && out_free;
    assign match     = pipe_valid_reg && (rd_data == note_reg);
    assign rd_addr   = base_reg + ADDR_W'(rd_idx_reg);
    assign wr_addr   = base_reg + ADDR_W'(cnt_reg);
    assign wr_data   = note_reg;

    always_comb begin
        state_next      = state_reg;
        rd_idx_next     = rd_idx_reg;
        pipe_valid_next = 1'b0;
        cnt_next        = cnt_reg;
        base_next       = base_reg;
        ch_idx_next     = ch_idx_reg;
        ch_next         = ch_reg;
        kind_next       = kind_reg;
        note_next       = note_reg;
        vel_next        = vel_reg;
        track_next      = track_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        cnt_wr          = 1'b0;
        cnt_wr_val      = '0;
        out_load        = 1'b0;
        out_word        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    ch_idx_next = s_ch_idx;
                    ch_next     = s_channel;
                    kind_next   = s_status_kind;
                    note_next   = s_note;
                    vel_next    = s_velocity;
                    track_next  = s_tracked;
                    cnt_next    = s_tracked ? cnt_tab_reg[s_ch_idx] : '0;
                    base_next   = ADDR_W'(s_ch_idx * MAX_HELD);
                    rd_idx_next = '0;
                    if (s_status_kind == hnt_pkg::ST_ALL_OFF) begin
                        if (s_tracked && (cnt_tab_reg[s_ch_idx] != '0)) begin
                            state_next = ST_FLUSH;
                        end
                    end else begin
                        state_next = ST_PASS;
                    end
                end
            end

            ST_PASS: begin
                if (out_free) begin
                    out_load             = 1'b1;
                    out_word.status_byte = kind_reg + {4'b0000, ch_reg};
                    out_word.data_one    = note_reg;
                    out_word.data_two    = vel_reg;
                    out_word.last        = 1'b1;
                    if ((kind_reg == hnt_pkg::ST_CTRL) || !track_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                // stream reads, compare each one once its registered read data returns
                rd_en           = more && !match;
                pipe_valid_next = rd_en;
                if (rd_en) begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (match) begin
                    state_next = ST_IDLE;
                end else if (!pipe_valid_reg && !more) begin
                    if (32'(cnt_reg) < MAX_HELD) begin
                        wr_en      = 1'b1;
                        cnt_wr     = 1'b1;
                        cnt_wr_val = cnt_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_FLUSH: begin
                // ram data holds until the output stage takes it
                rd_en           = more && (!pipe_valid_reg || consume);
                pipe_valid_next = rd_en || (pipe_valid_reg && !consume);
                if (rd_en) begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (consume) begin
                    out_load             = 1'b1;
                    out_word.status_byte = hnt_pkg::ST_ALL_OFF | {4'b0000, ch_reg};
                    out_word.data_one    = rd_data;
                    out_word.data_two    = '0;
                    out_word.last        = !more;
                    if (!more) begin
                        cnt_wr     = 1'b1;
                        cnt_wr_val = '0;
                        state_next = ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pipe_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pipe_valid_reg <= pipe_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_idx_next;
        cnt_reg    <= cnt_next;
        base_reg   <= base_next;
        ch_idx_reg <= ch_idx_next;
        ch_reg     <= ch_next;
        kind_reg   <= kind_next;
        note_reg   <= note_next;
        vel_reg    <= vel_next;
        track_reg  <= track_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                cnt_tab_reg[i] <= '0;
            end
        end else if (cnt_wr) begin
            cnt_tab_reg[ch_idx_reg] <= cnt_wr_val;
        end
    end

endmodule

[rtl/core/midi_held_note_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_held_note_tracker
// per-channel held note tracking with channel-wide note off release
// ----------------------------------------------------------------------------
// Each input word is one channel message. Status 0x80 releases the channel:
// one note-off word (0x80 | channel, note, 0) goes out for every held note,
// oldest first, m_last on the final one, and the channel list is emptied; an
// empty or untracked channel gives no word. Any other status goes out as one
// word, and unless it is a control change or the channel is untracked, the
// note is appended to the channel list when absent and the list is not full.
// The block handles one message at a time. A pass-through waits for the
// sink; a note message then runs a duplicate scan over the n held notes,
// ending early when the note is found, and a release waits for the sink on
// every word. Both are set by the single read port of the note memory, which
// delivers one entry per cycle, pausing while the sink stalls a release.
// ----------------------------------------------------------------------------
module midi_held_note_tracker #(
    parameter int CHANNELS = hnt_pkg::CHANNELS_DEF,
    parameter int MAX_HELD = hnt_pkg::MAX_HELD_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input words
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [hnt_pkg::KIND_W-1:0]  s_status_kind,
    input  logic [hnt_pkg::CHAN_W-1:0]  s_channel,
    input  logic [hnt_pkg::NOTE_W-1:0]  s_note,
    input  logic [hnt_pkg::VEL_W-1:0]   s_velocity,
    // output words
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [hnt_pkg::KIND_W-1:0]  m_status_byte,
    output logic [hnt_pkg::NOTE_W-1:0]  m_data_one,
    output logic [hnt_pkg::VEL_W-1:0]   m_data_two,
    output logic                        m_last
);

    // note memory holds one MAX_HELD slot per channel
    localparam int DEPTH  = CHANNELS * MAX_HELD;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                       rd_en;
    logic [ADDR_W-1:0]          rd_addr;
    logic [hnt_pkg::NOTE_W-1:0] rd_data;
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic [hnt_pkg::NOTE_W-1:0] wr_data;

    logic                       out_free;
    logic                       out_load;
    hnt_pkg::out_word_t         out_word;

    // output register
    logic                       m_valid_reg;
    hnt_pkg::out_word_t         m_word_reg;

    hnt_note_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    hnt_ctrl #(
        .CHANNELS (CHANNELS),
        .MAX_HELD (MAX_HELD),
        .ADDR_W   (ADDR_W)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_status_kind (s_status_kind),
        .s_channel     (s_channel),
        .s_note        (s_note),
        .s_velocity    (s_velocity),
        .out_free      (out_free),
        .out_load      (out_load),
        .out_word      (out_word),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data)
    );

    // slot can take a new word when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_word_reg <= out_word;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status_byte = m_word_reg.status_byte;
    assign m_data_one    = m_word_reg.data_one;
    assign m_data_two    = m_word_reg.data_two;
    assign m_last        = m_word_reg.last;

endmodule

[rtl/core/hnt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hnt_checker
// port-level checks for the held note tracker, bound to the top level
// ----------------------------------------------------------------------------
module hnt_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic [hnt_pkg::KIND_W-1:0]  s_status_kind,
    input logic [hnt_pkg::CHAN_W-1:0]  s_channel,
    input logic [hnt_pkg::NOTE_W-1:0]  s_note,
    input logic [hnt_pkg::VEL_W-1:0]   s_velocity,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [hnt_pkg::KIND_W-1:0]  m_status_byte,
    input logic [hnt_pkg::NOTE_W-1:0]  m_data_one,
    input logic [hnt_pkg::VEL_W-1:0]   m_data_two,
    input logic                        m_last
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status_byte)
            && $stable(m_data_one) && $stable(m_data_two) && $stable(m_last))
        else $error("output word changed while stalled");

    // only release words are non-final
    a_flush_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> (m_data_two == 7'd0) && (m_status_byte[7:4] == 4'h8))
        else $error("non-final word is not a note-off");

    // a release keeps the input closed until its final word
    a_flush_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("input open during a release");

    // a release runs without gaps
    a_flush_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |=> m_valid)
        else $error("gap inside a release");

    // a pass-through message always closes the input for a while
    a_pass_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_status_kind != hnt_pkg::ST_ALL_OFF) |=> !s_ready)
        else $error("input still open after a pass-through message");

endmodule

bind midi_held_note_tracker hnt_checker u_hnt_checker (.*);
